// File: rtl/mrbr_pkg.sv
// ----------------------------------------------------------------------------
// mrbr_pkg - shared types for the multiple-run byte reverser
// Command and status groups passed between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package mrbr_pkg;

    localparam int BYTE_W = 8;

    // controller -> datapath
    typedef struct packed {
        logic load;      // latch input beat, start remainder
        logic div_step;  // one nibble of the remainder
        logic push;      // push held byte onto the stack
        logic pop;       // read top of stack, decrement count
        logic emit;      // load output register
        logic emit_pass; // 1: the input byte, 0: the popped byte
        logic emit_last; // last result of this input beat
        logic emit_ovf;  // run released because the stack filled
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic match;     // byte is a multiple of the multiplier
        logic pkt_end;   // latched packet end flag
        logic cnt_zero;  // stack empty
        logic cnt_last;  // one push short of full
        logic out_free;  // output register can take a beat
    } t_sts;

endpackage

`default_nettype wire

// File: rtl/mrbr_dp.sv
// ----------------------------------------------------------------------------
// mrbr_dp - datapath of the multiple-run byte reverser
// Multiplier register, nibble-serial remainder unit, run stack memory and
// the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mrbr_dp #(
    parameter int RUN_DEPTH = 63
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [mrbr_pkg::BYTE_W-1:0] i_cfg_wdata,
    input  wire logic [mrbr_pkg::BYTE_W-1:0] i_byte,
    input  wire logic                       i_end,
    input  wire mrbr_pkg::t_cmd             i_cmd,
    output mrbr_pkg::t_sts                  o_sts,
    input  wire logic                       i_m_tready,
    output logic                            o_m_tvalid,
    output logic [mrbr_pkg::BYTE_W-1:0]      o_m_tdata,
    output logic                            o_m_tlast,
    output logic [1:0]                      o_m_tuser
);

    localparam int CNT_W  = $clog2(RUN_DEPTH + 1);
    localparam int ADDR_W = $clog2(RUN_DEPTH);
    localparam int NIB_W  = mrbr_pkg::BYTE_W / 2;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(RUN_DEPTH - 1);

    typedef logic [mrbr_pkg::BYTE_W-1:0] t_byte;

    t_byte            r_mult;
    t_byte            r_byte;
    logic             r_end;
    t_byte            r_div;
    t_byte            r_dvd;
    t_byte            r_rem;
    logic [CNT_W-1:0] r_cnt;
    t_byte            r_rd_data;
    t_byte            r_stack [RUN_DEPTH];

    logic             r_valid;
    t_byte            r_out_byte;
    logic             r_out_end;
    logic             r_out_last;
    logic             r_out_ovf;

    logic [CNT_W-1:0] n_cnt_dec;

    // restoring remainder over one nibble of dividend bits
    function automatic t_byte rem_nibble(input t_byte rem, input t_byte d,
                                         input logic [NIB_W-1:0] bits);
        logic [mrbr_pkg::BYTE_W:0] t;
        t_byte r;
        r = rem;
        for (int i = NIB_W - 1; i >= 0; i--) begin
            t = {r, bits[i]};
            if (t >= {1'b0, d})
                t = t - {1'b0, d};
            r = t[mrbr_pkg::BYTE_W-1:0];
        end
        return r;
    endfunction

    assign n_cnt_dec = r_cnt - CNT_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mult  <= '0;
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (i_cfg_we)
                r_mult <= i_cfg_wdata;
            if (i_cmd.push)
                r_cnt <= r_cnt + CNT_W'(1);
            else if (i_cmd.pop)
                r_cnt <= n_cnt_dec;
            if (i_cmd.emit)
                r_valid <= 1'b1;
            else if (i_m_tready)
                r_valid <= 1'b0;
        end
    end

    // payload and remainder registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_byte <= i_byte;
            r_end  <= i_end;
            r_div  <= r_mult;
            r_dvd  <= i_byte;
            r_rem  <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= rem_nibble(r_rem, r_div, r_dvd[mrbr_pkg::BYTE_W-1 -: NIB_W]);
            r_dvd <= {r_dvd[NIB_W-1:0], {NIB_W{1'b0}}};
        end
        if (i_cmd.emit) begin
            r_out_byte <= i_cmd.emit_pass ? r_byte : r_rd_data;
            r_out_last <= i_cmd.emit_last;
            r_out_end  <= i_cmd.emit_last & r_end;
            r_out_ovf  <= i_cmd.emit_ovf;
        end
    end

    // run stack
    always_ff @(posedge i_clk) begin
        if (i_cmd.push)
            r_stack[r_cnt[ADDR_W-1:0]] <= r_byte;
        if (i_cmd.pop)
            r_rd_data <= r_stack[n_cnt_dec[ADDR_W-1:0]];
    end

    assign o_sts.match    = (r_div != '0) && (r_rem == '0);
    assign o_sts.pkt_end  = r_end;
    assign o_sts.cnt_zero = (r_cnt == '0);
    assign o_sts.cnt_last = (r_cnt == CNT_LAST);
    assign o_sts.out_free = !r_valid || i_m_tready;

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = r_out_byte;
    assign o_m_tlast  = r_out_end;
    assign o_m_tuser  = {r_out_ovf, r_out_last};

endmodule

`default_nettype wire

// File: rtl/mrbr_ctrl.sv
// ----------------------------------------------------------------------------
// mrbr_ctrl - sequencer of the multiple-run byte reverser
// Steps the remainder, decides push or release, and walks the stack out.
// ----------------------------------------------------------------------------
`default_nettype none

module mrbr_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_s_tvalid,
    output logic                o_s_tready,
    input  wire mrbr_pkg::t_sts i_sts,
    output mrbr_pkg::t_cmd      o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV0,
        S_DIV1,
        S_DECIDE,
        S_RD,
        S_LD,
        S_PASS
    } t_state;

    t_state r_state;
    logic   r_pass;   // input byte still to follow the released run
    logic   r_ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pass  <= 1'b0;
            r_ovf   <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid)
                        r_state <= S_DIV0;
                end
                S_DIV0: r_state <= S_DIV1;
                S_DIV1: r_state <= S_DECIDE;
                S_DECIDE: begin
                    if (i_sts.match) begin
                        r_pass <= 1'b0;
                        if (i_sts.pkt_end) begin
                            r_ovf   <= 1'b0;
                            r_state <= S_RD;
                        end else if (i_sts.cnt_last) begin
                            r_ovf   <= 1'b1;
                            r_state <= S_RD;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end else begin
                        r_pass  <= 1'b1;
                        r_ovf   <= 1'b0;
                        r_state <= i_sts.cnt_zero ? S_PASS : S_RD;
                    end
                end
                S_RD: r_state <= S_LD;
                S_LD: begin
                    if (i_sts.out_free) begin
                        if (!i_sts.cnt_zero)
                            r_state <= S_RD;
                        else if (r_pass)
                            r_state <= S_PASS;
                        else
                            r_state <= S_IDLE;
                    end
                end
                S_PASS: begin
                    if (i_sts.out_free)
                        r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        o_cmd          = '0;
        o_s_tready     = (r_state == S_IDLE);
        o_cmd.load     = (r_state == S_IDLE) && i_s_tvalid;
        o_cmd.div_step = (r_state == S_DIV0) || (r_state == S_DIV1);
        o_cmd.push     = (r_state == S_DECIDE) && i_sts.match;
        o_cmd.pop      = (r_state == S_RD);
        if (r_state == S_LD) begin
            o_cmd.emit      = i_sts.out_free;
            o_cmd.emit_last = i_sts.cnt_zero && !r_pass;
            o_cmd.emit_ovf  = r_ovf;
        end
        if (r_state == S_PASS) begin
            o_cmd.emit      = i_sts.out_free;
            o_cmd.emit_pass = 1'b1;
            o_cmd.emit_last = 1'b1;
        end
    end

endmodule

`default_nettype wire

// File: rtl/multiple_run_byte_reverser.sv
// ----------------------------------------------------------------------------
// multiple_run_byte_reverser - reverses runs of bytes that are multiples of a
// configured value
// ----------------------------------------------------------------------------
// A beat is taken only while the block is idle. Each byte passes through
// accept, two nibble steps of the remainder unit and decide before it is held
// or released; a held byte gives no output beat. A release pops the stack
// through its single registered read port, and a non-matching byte then
// follows the run as a beat of its own. Output beats wait in a register,
// so downstream stalls only slow the release. Multiplier of zero passes every
// byte. tuser[0] marks the last beat caused by one input beat, tuser[1] a run
// released because the stack filled. No clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module multiple_run_byte_reverser #(
    parameter int RUN_DEPTH = 63
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [7:0] i_cfg_wdata,   // multiplier
    input  wire logic       i_s_tvalid,
    output logic            o_s_tready,
    input  wire logic [7:0] i_s_tdata,     // [7:0] data_byte
    input  wire logic       i_s_tlast,     // packet_end
    output logic            o_m_tvalid,
    input  wire logic       i_m_tready,
    output logic [7:0]      o_m_tdata,     // [7:0] out_byte
    output logic            o_m_tlast,     // out_packet_end
    output logic [1:0]      o_m_tuser      // [0] last_of_run, [1] overflow
);

    mrbr_pkg::t_cmd w_cmd;
    mrbr_pkg::t_sts w_sts;

    mrbr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    mrbr_dp #(
        .RUN_DEPTH (RUN_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_byte      (i_s_tdata),
        .i_end       (i_s_tlast),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_m_tready  (i_m_tready),
        .o_m_tvalid  (o_m_tvalid),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .o_m_tuser   (o_m_tuser)
    );

endmodule

`default_nettype wire

// File: rtl/mrbr_checker.sv
// ----------------------------------------------------------------------------
// mrbr_checker - port-level checks for the multiple-run byte reverser
// Attached to the top level by the bind below.
// ----------------------------------------------------------------------------
`default_nettype none

module mrbr_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_s_tvalid,
    input wire logic       o_s_tready,
    input wire logic       o_m_tvalid,
    input wire logic       i_m_tready,
    input wire logic [7:0] o_m_tdata,
    input wire logic       o_m_tlast,
    input wire logic [1:0] o_m_tuser
);

    // packet end only on the final beat of an input beat's results
    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tlast |-> o_m_tuser[0])
        else $error("packet end without last_of_run");

    // an overflow release never carries packet end
    a_ovf_no_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[1] |-> !o_m_tlast)
        else $error("overflow beat flagged as packet end");

    // no second beat taken while the remainder is being worked out
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready ##1 !o_s_tready)
        else $error("input taken during remainder steps");

    // stalled output beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tlast) && $stable(o_m_tuser))
        else $error("stalled output beat changed");

endmodule

bind multiple_run_byte_reverser mrbr_checker u_mrbr_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast),
    .o_m_tuser  (o_m_tuser)
);

`default_nettype wire
